// ----- hdl/dwr_pkg.sv -----
package dwr_pkg;

  localparam int VAL_W            = 32;
  localparam int CMD_W            = 3;
  localparam int DEF_DEPTH        = 16;
  localparam int DEF_ELEM_WIDTH   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_REVERSE   = 3'd4,
    CMD_PALIN     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PAL_RD,
    S_PAL_CMP,
    S_ENDS_RD,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic exec;      // apply the command to pointers, count, flag and store
    logic pal_rd;    // read the current element pair
    logic pal_cmp;   // compare the pair and step inward
    logic ends_rd;   // read the first and last element
    logic resp;      // load the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pal_need;  // palindrome check with at least two elements
    logic pal_go_on; // pair matched and more pairs remain
    logic out_free;  // output register can take a new beat
  } stat_t;

endpackage

// ----- hdl/deque_with_reverse_palindrome_top.sv -----
// Bounded double-ended queue of DEPTH elements, ELEM_WIDTH bits each, held in a
// circular RAM with a start pointer, a count and a direction flag. Each input
// beat carries one command (add front/back, remove front/back, reverse,
// palindrome check) and yields exactly one output beat with status, palindrome
// verdict, empty flag, count and the front and back values after the command.
// The block works on one beat at a time. An accepted beat is captured, then
// executed on pointers, count, flag and RAM, then the first and last elements
// are read and the output register loads; adds, removes, reverse and unused
// codes take this path. A palindrome check on n >= 2 elements walks k <= n/2
// element pairs between execute and the end read, up to and including the
// first mismatch or the middle; the RAM read of each pair is registered
// before its compare. A new beat is taken once the previous result sits in the
// output register, even while that result is stalled; a stalled result holds
// the next one in its final state.
module deque_with_reverse_palindrome_top
  import dwr_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CMD_W-1:0]           command_i,
  input  logic [VAL_W-1:0]           element_value_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic                       is_palindrome_o,
  output logic                       list_empty_o,
  output logic [$clog2(DEPTH+1)-1:0] element_count_o,
  output logic [VAL_W-1:0]           front_value_o,
  output logic [VAL_W-1:0]           back_value_o
);

  ctl_t  ctl;
  stat_t stat;

  // Sequencer: accept, execute, walk pairs, read ends, deliver the beat.
  dwr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  // Pointers, count, direction flag, element RAM and output register.
  dwr_dpath #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .command_i      (command_i),
    .element_value_i(element_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .is_palindrome_o(is_palindrome_o),
    .list_empty_o   (list_empty_o),
    .element_count_o(element_count_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

endmodule

// ----- hdl/dwr_ram.sv -----
module dwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- hdl/dwr_ctrl.sv -----
module dwr_ctrl
  import dwr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = stat_i.pal_need ? S_PAL_RD : S_ENDS_RD;
      end
      S_PAL_RD: begin
        ctl_o.pal_rd = 1'b1;
        state_d      = S_PAL_CMP;
      end
      S_PAL_CMP: begin
        ctl_o.pal_cmp = 1'b1;
        state_d       = stat_i.pal_go_on ? S_PAL_RD : S_ENDS_RD;
      end
      S_ENDS_RD: begin
        ctl_o.ends_rd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        // hold until the output register drains
        if (stat_i.out_free) begin
          ctl_o.resp = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/dwr_dpath.sv -----
module dwr_dpath
  import dwr_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctl_t                       ctl_i,
  output stat_t                      stat_o,
  input  logic [CMD_W-1:0]           command_i,
  input  logic [VAL_W-1:0]           element_value_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic                       is_palindrome_o,
  output logic                       list_empty_o,
  output logic [$clog2(DEPTH+1)-1:0] element_count_o,
  output logic [VAL_W-1:0]           front_value_o,
  output logic [VAL_W-1:0]           back_value_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ELEM_WIDTH;
  localparam int XW = (EW > VAL_W) ? EW : VAL_W;

  // Physical slot of offset k from base, wrapping at DEPTH.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]    start_q, start_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic             rev_q, rev_d;
  logic [CMD_W-1:0] cmd_q;
  logic [EW-1:0]    val_q;
  status_e          sts_q, sts_d;
  logic             pal_q, pal_d;
  logic [CW-1:0]    i_q, i_d;
  logic [CW-1:0]    j_q, j_d;
  logic             out_valid_q;

  logic [XW-1:0]    in_ext;
  logic             full, empty, at_front;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [CW-1:0]    last_off;
  logic [EW-1:0]    rd_a, rd_b;
  logic [EW-1:0]    front_elem, back_elem;
  logic [XW-1:0]    front_ext, back_ext;

  assign in_ext   = XW'(element_value_i);
  assign full     = (occ_q == CW'(DEPTH));
  assign empty    = (occ_q == '0);
  assign last_off = empty ? '0 : occ_q - CW'(1);

  // Payload capture, plus status, verdict and pair index registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= command_i;
      val_q <= in_ext[EW-1:0];
    end
    sts_q <= sts_d;
    pal_q <= pal_d;
    i_q   <= i_d;
    j_q   <= j_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      occ_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= start_d;
      occ_q   <= occ_d;
      rev_q   <= rev_d;
      if (ctl_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    start_d  = start_q;
    occ_d    = occ_q;
    rev_d    = rev_q;
    sts_d    = sts_q;
    pal_d    = pal_q;
    i_d      = i_q;
    j_d      = j_q;
    we       = 1'b0;
    waddr    = slot(start_q, occ_q);
    at_front = 1'b0;
    if (ctl_i.exec) begin
      sts_d = STS_OK;
      pal_d = 1'b0;
      i_d   = '0;
      j_d   = last_off;
      unique case (cmd_q)
        CMD_ADD_FRONT, CMD_ADD_BACK: begin
          at_front = (cmd_q == CMD_ADD_FRONT) ^ rev_q;
          if (full) begin
            sts_d = STS_FULL;
          end else begin
            we    = 1'b1;
            occ_d = occ_q + CW'(1);
            if (at_front) begin
              start_d = (start_q == '0) ? AW'(DEPTH - 1) : start_q - AW'(1);
              waddr   = start_d;
            end
          end
        end
        CMD_REM_FRONT, CMD_REM_BACK: begin
          at_front = (cmd_q == CMD_REM_FRONT) ^ rev_q;
          if (empty) begin
            sts_d = STS_EMPTY;
          end else begin
            occ_d = occ_q - CW'(1);
            if (at_front) begin
              start_d = (start_q == AW'(DEPTH - 1)) ? '0 : start_q + AW'(1);
            end
          end
        end
        CMD_REVERSE: begin
          if (empty) begin
            sts_d = STS_EMPTY;
          end else begin
            rev_d = ~rev_q;
          end
        end
        CMD_PALIN: begin
          if (empty) begin
            sts_d = STS_EMPTY;
          end else begin
            pal_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ctl_i.pal_cmp) begin
      if (rd_a != rd_b) begin
        pal_d = 1'b0;
      end
      i_d = i_q + CW'(1);
      j_d = j_q - CW'(1);
    end
  end

  // Pair walk or end reads share the two read ports
  assign raddr_a = ctl_i.ends_rd ? start_q : slot(start_q, i_q);
  assign raddr_b = ctl_i.ends_rd ? slot(start_q, last_off) : slot(start_q, j_q);

  dwr_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (val_q),
    .re_i     (ctl_i.pal_rd | ctl_i.ends_rd),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign stat_o.pal_need  = (cmd_q == CMD_PALIN) && (occ_q > CW'(1));
  assign stat_o.pal_go_on = (rd_a == rd_b) && ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(j_q));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign front_elem = empty ? '0 : (rev_q ? rd_b : rd_a);
  assign back_elem  = empty ? '0 : (rev_q ? rd_a : rd_b);
  assign front_ext  = XW'(front_elem);
  assign back_ext   = XW'(back_elem);

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.resp) begin
      status_o        <= sts_q;
      is_palindrome_o <= pal_q;
      list_empty_o    <= empty;
      element_count_o <= occ_q;
      front_value_o   <= front_ext[VAL_W-1:0];
      back_value_o    <= back_ext[VAL_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- tb/deque_result_check.sv -----
module deque_result_check
  import dwr_pkg::*;
#(
  parameter int DEPTH   = DEF_DEPTH,
  parameter int COUNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [VAL_W-1:0]   element_value_i,
  // result channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic               is_palindrome_i,
  input  logic               list_empty_i,
  input  logic [COUNT_W-1:0] element_count_i,
  input  logic [VAL_W-1:0]   front_value_i,
  input  logic [VAL_W-1:0]   back_value_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_W = $clog2(DEPTH);

  typedef struct packed {
    status_e            status;
    logic               palindrome;
    logic               empty;
    logic [COUNT_W-1:0] count;
    logic [VAL_W-1:0]   front;
    logic [VAL_W-1:0]   back;
  } deque_view_t;

  // Shadow deque: circular slots, physical head, fill level, direction flag.
  logic [VAL_W-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   head;
  logic [COUNT_W-1:0] fill;
  logic               flipped;

  deque_view_t        awaited_views[$];
  deque_view_t        want;

  function automatic logic [PTR_W-1:0] slot_at(input int k);
    return PTR_W'((int'(head) + k) % DEPTH);
  endfunction

  // Apply one command to the shadow deque and return the view it leaves.
  function automatic deque_view_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [VAL_W-1:0] val);
    deque_view_t view;
    logic        at_phys_front;
    logic [VAL_W-1:0] first_v;
    logic [VAL_W-1:0] last_v;
    view.status     = STS_OK;
    view.palindrome = 1'b0;
    view.front      = '0;
    view.back       = '0;
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        if (fill == COUNT_W'(DEPTH)) begin
          view.status = STS_FULL;
        end else begin
          // a logical front add lands on the physical back while flipped
          at_phys_front = (cmd == CMD_ADD_FRONT) ^ flipped;
          if (at_phys_front) begin
            head = PTR_W'((int'(head) + DEPTH - 1) % DEPTH);
            slots[head] = val;
          end else begin
            slots[slot_at(int'(fill))] = val;
          end
          fill = fill + 1'b1;
        end
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (fill == '0) begin
          view.status = STS_EMPTY;
        end else begin
          at_phys_front = (cmd == CMD_REM_FRONT) ^ flipped;
          if (at_phys_front) head = PTR_W'((int'(head) + 1) % DEPTH);
          fill = fill - 1'b1;
        end
      end
      CMD_REVERSE: begin
        if (fill == '0) view.status = STS_EMPTY;
        else flipped = !flipped;
      end
      CMD_PALIN: begin
        if (fill == '0) begin
          view.status = STS_EMPTY;
        end else begin
          view.palindrome = 1'b1;
          for (int i = 0; i < int'(fill) / 2; i++) begin
            if (slots[slot_at(i)] != slots[slot_at(int'(fill) - 1 - i)])
              view.palindrome = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (fill != '0) begin
      first_v    = slots[slot_at(0)];
      last_v     = slots[slot_at(int'(fill) - 1)];
      view.front = flipped ? last_v : first_v;
      view.back  = flipped ? first_v : last_v;
    end
    view.empty = (fill == '0);
    view.count = fill;
    return view;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                             input logic [VAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head    = '0;
      fill    = '0;
      flipped = 1'b0;
      awaited_views.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_views.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fail_count_o++;
        end else begin
          want = awaited_views.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(status_i));
          check_field("is_palindrome", VAL_W'(want.palindrome), VAL_W'(is_palindrome_i));
          check_field("list_empty", VAL_W'(want.empty), VAL_W'(list_empty_i));
          check_field("element_count", VAL_W'(want.count), VAL_W'(element_count_i));
          check_field("front_value", want.front, front_value_i);
          check_field("back_value", want.back, back_value_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_views.push_back(apply_command(command_i, element_value_i));
      pending_o <= awaited_views.size();
    end
  end

endmodule

// ----- tb/deque_with_reverse_palindrome_top_tb.sv -----
module deque_with_reverse_palindrome_top_tb
  import dwr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = DEF_DEPTH;
  localparam int COUNT_W        = $clog2(DEPTH + 1);
  localparam int TARGET_ITEMS   = 2000;
  // Longest honest quiet stretch is a long sender gap plus a full palindrome
  // walk plus a few chained long receiver stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_SETTLE   = 40;

  // Codes the block decodes as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic               clk_i         = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command       = '0;
  logic [VAL_W-1:0]   element_value = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         status;
  logic               is_palindrome;
  logic               list_empty;
  logic [COUNT_W-1:0] element_count;
  logic [VAL_W-1:0]   front_value;
  logic [VAL_W-1:0]   back_value;

  int                 fail_count;
  int                 pending;
  int                 items_sent   = 0;
  int                 quiet_cycles = 0;
  int                 stall_hold   = 0;
  logic               no_idle      = 1'b0;

  always #5 clk_i = ~clk_i;

  deque_with_reverse_palindrome_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .element_value_i(element_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .is_palindrome_o(is_palindrome),
    .list_empty_o   (list_empty),
    .element_count_o(element_count),
    .front_value_o  (front_value),
    .back_value_o   (back_value)
  );

  deque_result_check #(.DEPTH(DEPTH)) u_result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .element_value_i(element_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .is_palindrome_i(is_palindrome),
    .list_empty_i   (list_empty),
    .element_count_i(element_count),
    .front_value_i  (front_value),
    .back_value_i   (back_value),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values: lean on a tiny alphabet so pairs often match, keep the
  // extremes in play, and let full-width random words toggle every bit.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return VAL_W'($urandom_range(0, 3));
      default:    return VAL_W'($urandom());
    endcase
  endfunction

  // Present one command beat and hold it until the block takes it. Valid
  // only drops when a gap is due, so back-to-back beats keep it high.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : pick_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    element_value <= val;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (cmd <= CMD_PALIN) items_sent++;
  endtask

  task automatic send_add(input logic [VAL_W-1:0] val);
    send_beat($urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK, val);
  endtask

  // Push past capacity from any level: the tail end hits the full error.
  task automatic fill_up();
    repeat (DEPTH + 1) send_add(pick_value());
  endtask

  // Pop past empty from any level, with the odd direction flip mixed in.
  task automatic drain_all();
    repeat (DEPTH + 1) begin
      if ($urandom_range(0, 7) == 0) send_beat(CMD_REVERSE, pick_value());
      send_beat($urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK, pick_value());
    end
  endtask

  // Grow a mirror image around the old or drained contents plus an optional
  // middle; check it, maybe flip and recheck, maybe unbalance it and recheck.
  task automatic build_palindrome();
    int               pairs;
    logic [VAL_W-1:0] v;
    if ($urandom_range(0, 1)) drain_all();
    if ($urandom_range(0, 1)) send_add(pick_value());
    pairs = $urandom_range(1, DEPTH / 2);
    repeat (pairs) begin
      v = pick_value();
      if ($urandom_range(0, 1)) begin
        send_beat(CMD_ADD_FRONT, v);
        send_beat(CMD_ADD_BACK, v);
      end else begin
        send_beat(CMD_ADD_BACK, v);
        send_beat(CMD_ADD_FRONT, v);
      end
    end
    send_beat(CMD_PALIN, pick_value());
    if ($urandom_range(0, 1)) begin
      send_beat(CMD_REVERSE, pick_value());
      send_beat(CMD_PALIN, pick_value());
    end
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) send_add(pick_value());
      else send_beat($urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK, pick_value());
      send_beat(CMD_PALIN, pick_value());
    end
  endtask

  // Unstructured traffic over every code, spare ones included.
  task automatic noise_burst();
    repeat ($urandom_range(8, 30))
      send_beat(CMD_W'($urandom_range(0, 7)), pick_value());
  endtask

  // Receiver side: hold stall or release for a random stretch, except in
  // the full-rate episodes.
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= no_idle ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_hold <= pick_span();
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("deque_with_reverse_palindrome_top regression: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Everything on an empty deque: removes, reverse and palindrome check all
    // report the empty error; spare codes are no-ops.
    send_beat(CMD_REM_FRONT, '1);
    send_beat(CMD_REM_BACK, '0);
    send_beat(CMD_REVERSE, '1);
    send_beat(CMD_PALIN, '0);
    send_beat(CMD_SPARE_LO, '1);
    send_beat(CMD_SPARE_HI, '0);
    // Single element reads as a palindrome; two unequal ends do not.
    send_beat(CMD_ADD_FRONT, '0);
    send_beat(CMD_PALIN, '0);
    send_beat(CMD_ADD_BACK, '1);
    send_beat(CMD_PALIN, '0);
    // Flip, then take both ends off under the flipped order.
    send_beat(CMD_REVERSE, '0);
    send_beat(CMD_REM_FRONT, '0);
    send_beat(CMD_REM_BACK, '1);
    // Run up against the full error and back down once for certain.
    fill_up();
    drain_all();

    // Random episodes, palindrome builds with random content most often.
    while (items_sent < TARGET_ITEMS) begin
      no_idle <= ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: build_palindrome();
        4:          fill_up();
        5, 6:       drain_all();
        default:    noise_burst();
      endcase
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    // Wait out every outstanding result, then let any stray beat surface.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("deque_with_reverse_palindrome_top regression: pass");
    end else begin
      $display("deque_with_reverse_palindrome_top regression: fail");
    end
    $finish;
  end

endmodule
